/* hdl/pcbb_pkg.sv */
package pcbb_pkg;

    localparam int MAX_KEY_BYTES = 32;
    localparam int MAX_RESTARTS  = 32;

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_CW = $clog2(MAX_KEY_BYTES + 1);
    localparam int RST_AW = (MAX_RESTARTS > 1) ? $clog2(MAX_RESTARTS) : 1;
    localparam int RST_CW = $clog2(MAX_RESTARTS + 1);

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_BEGIN  = 2'd0;
    localparam cmd_t CMD_KEY    = 2'd1;
    localparam cmd_t CMD_VALUE  = 2'd2;
    localparam cmd_t CMD_FINISH = 2'd3;

    localparam logic [2:0] WORD_BYTES     = 3'd4;
    localparam logic [2:0] SINGLE_BYTE    = 3'd1;
    localparam logic [7:0] INTERVAL_RESET = 8'd16;

endpackage

/* hdl/pcbb_ram.sv */
module pcbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/prefix_compressed_block_builder.sv */
// channel | dir | handshake                 | payload
// s_      | in  | s_tvalid / s_tready       | tdata: byte, key len, value len; tuser: command
// m_      | out | m_tvalid / m_tready       | tdata: word, byte count; tuser: end, overflow
// cfg_    | in  | cfg_valid / cfg_ready     | cfg_data: restart interval
//
// value byte: goes straight to the output register when it is free, else waits in a hold stage
// key byte: key store read, then compare; the last one adds 3 header words
// plus read and pack steps per unshared key byte; header and packed words wait on m_tready
// finish: a restart store read and an output step per restart word, then the count word
// aresetn is synchronous; both stores hold garbage after reset and need no clearing
module prefix_compressed_block_builder
    import pcbb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_byte, key_length, value_length, zero pad
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_word, byte_count, zero pad
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // block_end, overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_KCMP = 4'd1;
    localparam logic [3:0] ST_HDR  = 4'd2;
    localparam logic [3:0] ST_KRD  = 4'd3;
    localparam logic [3:0] ST_KACC = 4'd4;
    localparam logic [3:0] ST_KOUT = 4'd5;
    localparam logic [3:0] ST_VAL  = 4'd6;
    localparam logic [3:0] ST_RRD  = 4'd7;
    localparam logic [3:0] ST_ROUT = 4'd8;
    localparam logic [3:0] ST_RCNT = 4'd9;

    localparam logic [1:0] HDR_SHARED   = 2'd0;
    localparam logic [1:0] HDR_UNSHARED = 2'd1;
    localparam logic [1:0] HDR_VALUE    = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [7:0]        interval_reg;
    logic [KEY_CW-1:0] prev_len_reg, prev_len_next;
    logic [KEY_CW-1:0] cur_len_reg, cur_len_next;
    logic [KEY_CW-1:0] seen_reg, seen_next;
    logic [KEY_CW-1:0] shared_reg, shared_next;
    logic              match_reg, match_next;
    logic [15:0]       pend_reg, pend_next;
    logic [7:0]        group_reg, group_next;
    logic [RST_CW-1:0] rcount_reg, rcount_next;
    logic [31:0]       body_reg, body_next;
    logic              ovf_reg, ovf_next;
    logic [1:0]        hdr_idx_reg, hdr_idx_next;
    logic [KEY_CW-1:0] ptr_reg, ptr_next;
    logic [31:0]       pack_reg, pack_next;
    logic [2:0]        pack_cnt_reg, pack_cnt_next;
    logic [RST_CW-1:0] ridx_reg, ridx_next;
    logic [7:0]        hold_byte_reg, hold_byte_next;
    logic [KEY_CW-1:0] hold_idx_reg, hold_idx_next;

    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_word_reg, m_word_next;
    logic [2:0]        m_cnt_reg, m_cnt_next;
    logic              m_last_reg, m_last_next;
    logic              m_end_reg, m_end_next;
    logic              m_ovf_reg, m_ovf_next;

    logic              key_we;
    logic [KEY_AW-1:0] key_raddr;
    logic [7:0]        key_rdata;
    logic              rst_we;
    logic [31:0]       rst_rdata;

    logic              s_accept;
    logic              out_free;
    cmd_t              in_cmd;
    logic [7:0]        in_byte;
    logic [5:0]        in_klen;
    logic [15:0]       in_vlen;
    logic [KEY_CW-1:0] shared_eff;

    logic [7:0]        iv;
    logic              restart;
    logic [8:0]        grp_sum;
    logic [KEY_CW-1:0] klen;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign in_cmd  = s_tuser;
    assign in_byte = s_tdata[7:0];
    assign in_klen = s_tdata[13:8];
    assign in_vlen = s_tdata[29:14];

    assign shared_eff = (shared_reg > cur_len_reg) ? cur_len_reg : shared_reg;
    assign key_raddr  = (state_reg == ST_IDLE) ? seen_reg[KEY_AW-1:0] : ptr_reg[KEY_AW-1:0];

    assign iv      = (interval_reg == 8'd0) ? 8'd1 : interval_reg;
    assign restart = (group_reg == 8'd0) || (group_reg >= iv);
    assign grp_sum = (restart ? 9'd0 : {1'b0, group_reg}) + 9'd1;
    assign klen    = (int'(in_klen) > MAX_KEY_BYTES) ? KEY_CW'(MAX_KEY_BYTES)
                                                     : KEY_CW'(in_klen);

    assign rst_we = s_accept && (in_cmd == CMD_BEGIN) && restart
                    && (int'(rcount_reg) < MAX_RESTARTS);
    assign key_we = s_accept && (in_cmd == CMD_KEY) && (seen_reg < cur_len_reg);

    pcbb_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (seen_reg[KEY_AW-1:0]),
        .wdata (in_byte),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    pcbb_ram #(.WIDTH(32), .DEPTH(MAX_RESTARTS)) u_rst_ram (
        .aclk  (aclk),
        .we    (rst_we),
        .waddr (rcount_reg[RST_AW-1:0]),
        .wdata (body_reg),
        .raddr (ridx_reg[RST_AW-1:0]),
        .rdata (rst_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        prev_len_next  = prev_len_reg;
        cur_len_next   = cur_len_reg;
        seen_next      = seen_reg;
        shared_next    = shared_reg;
        match_next     = match_reg;
        pend_next      = pend_reg;
        group_next     = group_reg;
        rcount_next    = rcount_reg;
        body_next      = body_reg;
        ovf_next       = ovf_reg;
        hdr_idx_next   = hdr_idx_reg;
        ptr_next       = ptr_reg;
        pack_next      = pack_reg;
        pack_cnt_next  = pack_cnt_reg;
        ridx_next      = ridx_reg;
        hold_byte_next = hold_byte_reg;
        hold_idx_next  = hold_idx_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_word_next  = m_word_reg;
        m_cnt_next   = m_cnt_reg;
        m_last_next  = m_last_reg;
        m_end_next   = m_end_reg;
        m_ovf_next   = m_ovf_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (in_cmd)
                        CMD_BEGIN: begin
                            if (seen_reg < cur_len_reg) begin
                                prev_len_next = seen_reg;
                            end
                            if (restart) begin
                                if (int'(rcount_reg) < MAX_RESTARTS) begin
                                    rcount_next = rcount_reg + 1'b1;
                                end else begin
                                    ovf_next = 1'b1;
                                end
                            end
                            group_next   = (grp_sum >= {1'b0, iv}) ? 8'd0 : grp_sum[7:0];
                            cur_len_next = klen;
                            seen_next    = '0;
                            shared_next  = '0;
                            match_next   = !restart;
                            pend_next    = in_vlen;
                            if (klen == '0) begin
                                prev_len_next = '0;
                                hdr_idx_next  = HDR_SHARED;
                                state_next    = ST_HDR;
                            end
                        end
                        CMD_KEY: begin
                            if (seen_reg < cur_len_reg) begin
                                hold_byte_next = in_byte;
                                hold_idx_next  = seen_reg;
                                seen_next      = seen_reg + 1'b1;
                                state_next     = ST_KCMP;
                            end
                        end
                        CMD_VALUE: begin
                            if (seen_reg == cur_len_reg && pend_reg != 16'd0) begin
                                pend_next = pend_reg - 16'd1;
                                body_next = body_reg + 32'd1;
                                if (out_free) begin
                                    m_valid_next = 1'b1;
                                    m_word_next  = {24'd0, in_byte};
                                    m_cnt_next   = SINGLE_BYTE;
                                    m_last_next  = 1'b1;
                                    m_end_next   = 1'b0;
                                    m_ovf_next   = ovf_reg;
                                end else begin
                                    hold_byte_next = in_byte;
                                    state_next     = ST_VAL;
                                end
                            end
                        end
                        CMD_FINISH: begin
                            ridx_next  = '0;
                            state_next = ST_RRD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_KCMP: begin
                if (match_reg && hold_idx_reg < prev_len_reg && key_rdata == hold_byte_reg) begin
                    shared_next = shared_reg + 1'b1;
                end else begin
                    match_next = 1'b0;
                end
                if (seen_reg == cur_len_reg) begin
                    prev_len_next = cur_len_reg;
                    hdr_idx_next  = HDR_SHARED;
                    state_next    = ST_HDR;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_HDR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_cnt_next   = WORD_BYTES;
                    m_end_next   = 1'b0;
                    m_ovf_next   = ovf_reg;
                    m_last_next  = 1'b0;
                    case (hdr_idx_reg)
                        HDR_SHARED:   m_word_next = 32'(shared_eff);
                        HDR_UNSHARED: m_word_next = 32'(cur_len_reg - shared_eff);
                        default:      m_word_next = {16'd0, pend_reg};
                    endcase
                    if (hdr_idx_reg == HDR_VALUE) begin
                        body_next     = body_reg + 32'd12;
                        ptr_next      = shared_eff;
                        pack_next     = '0;
                        pack_cnt_next = '0;
                        if (shared_eff == cur_len_reg) begin
                            m_last_next = 1'b1;
                            state_next  = ST_IDLE;
                        end else begin
                            state_next = ST_KRD;
                        end
                    end else begin
                        hdr_idx_next = hdr_idx_reg + 2'd1;
                    end
                end
            end
            ST_KRD: begin
                state_next = ST_KACC;
            end
            ST_KACC: begin
                pack_next[{pack_cnt_reg[1:0], 3'b000} +: 8] = key_rdata;
                pack_cnt_next = pack_cnt_reg + 3'd1;
                ptr_next      = ptr_reg + 1'b1;
                if (pack_cnt_reg == 3'd3 || ptr_reg + 1'b1 == cur_len_reg) begin
                    state_next = ST_KOUT;
                end else begin
                    state_next = ST_KRD;
                end
            end
            ST_KOUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_word_next   = pack_reg;
                    m_cnt_next    = pack_cnt_reg;
                    m_last_next   = (ptr_reg == cur_len_reg);
                    m_end_next    = 1'b0;
                    m_ovf_next    = ovf_reg;
                    body_next     = body_reg + 32'(pack_cnt_reg);
                    pack_next     = '0;
                    pack_cnt_next = '0;
                    state_next    = (ptr_reg == cur_len_reg) ? ST_IDLE : ST_KRD;
                end
            end
            ST_VAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = {24'd0, hold_byte_reg};
                    m_cnt_next   = SINGLE_BYTE;
                    m_last_next  = 1'b1;
                    m_end_next   = 1'b0;
                    m_ovf_next   = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_RRD: begin
                state_next = (ridx_reg < rcount_reg) ? ST_ROUT : ST_RCNT;
            end
            ST_ROUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = rst_rdata;
                    m_cnt_next   = WORD_BYTES;
                    m_last_next  = 1'b0;
                    m_end_next   = 1'b0;
                    m_ovf_next   = ovf_reg;
                    ridx_next    = ridx_reg + 1'b1;
                    state_next   = ST_RRD;
                end
            end
            ST_RCNT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_word_next   = 32'(rcount_reg);
                    m_cnt_next    = WORD_BYTES;
                    m_last_next   = 1'b1;
                    m_end_next    = 1'b1;
                    m_ovf_next    = ovf_reg;
                    prev_len_next = '0;
                    cur_len_next  = '0;
                    seen_next     = '0;
                    shared_next   = '0;
                    match_next    = 1'b0;
                    pend_next     = '0;
                    group_next    = '0;
                    rcount_next   = '0;
                    body_next     = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            interval_reg <= INTERVAL_RESET;
            prev_len_reg <= '0;
            cur_len_reg  <= '0;
            seen_reg     <= '0;
            shared_reg   <= '0;
            match_reg    <= 1'b0;
            pend_reg     <= '0;
            group_reg    <= '0;
            rcount_reg   <= '0;
            body_reg     <= '0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_valid && cfg_ready) begin
                interval_reg <= cfg_data;
            end
            prev_len_reg <= prev_len_next;
            cur_len_reg  <= cur_len_next;
            seen_reg     <= seen_next;
            shared_reg   <= shared_next;
            match_reg    <= match_next;
            pend_reg     <= pend_next;
            group_reg    <= group_next;
            rcount_reg   <= rcount_next;
            body_reg     <= body_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_idx_reg   <= hdr_idx_next;
        ptr_reg       <= ptr_next;
        pack_reg      <= pack_next;
        pack_cnt_reg  <= pack_cnt_next;
        ridx_reg      <= ridx_next;
        hold_byte_reg <= hold_byte_next;
        hold_idx_reg  <= hold_idx_next;
        m_word_reg    <= m_word_next;
        m_cnt_reg     <= m_cnt_next;
        m_last_reg    <= m_last_next;
        m_end_reg     <= m_end_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_cnt_reg, m_word_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_ovf_reg, m_end_reg};

endmodule

/* hdl/pcbb_checker.sv */
module pcbb_checker
    import pcbb_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // closing word ends its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("block end word without tlast");

    // closing word carries a full count word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[34:32] == WORD_BYTES)
        else $error("block end word with short byte count");

    // byte count between one and four
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:32] != 3'd0 && m_tdata[34:32] <= WORD_BYTES)
        else $error("byte count out of range");

    // finish starts the restart drain, input closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == CMD_FINISH |=> !s_tready)
        else $error("input taken during restart drain");

    // stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

endmodule

bind prefix_compressed_block_builder pcbb_checker u_pcbb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* dv/testbench.sv */
module testbench;
    import pcbb_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
        logic        blk_end;
        logic        ovf;
    } block_word_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [7:0]       data;
        logic [5:0]       klen;
        logic [15:0]      vlen;
        logic [1:0]       n_known;
        logic [2:0]       known_bytes;
        logic             known_end;
        logic [2:0][31:0] known_word;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // data_byte, key_length, value_length, zero pad
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_word, byte_count, zero pad
    logic        m_tlast;
    logic [1:0]  m_tuser;   // block_end, overflow
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    prefix_compressed_block_builder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predicted block state
    logic [7:0]        key_mem [MAX_KEY_BYTES];
    logic [31:0]       restart_mem [MAX_RESTARTS];
    logic [KEY_CW-1:0] prev_key_len;
    logic [KEY_CW-1:0] cur_key_len;
    logic [KEY_CW-1:0] keys_seen;
    logic [KEY_CW-1:0] shared_len;
    logic              matching;
    logic [15:0]       value_left;
    logic [7:0]        group_pos;
    logic [RST_CW-1:0] restart_cnt;
    logic [31:0]       body_offset;
    logic              overflow_seen;
    logic [7:0]        interval_reg;

    block_word_t expected_block_words [$];
    block_word_t held_word;
    logic        word_held;
    int          words_last_item;

    int          errors;
    int          items_sent;
    int          quiet_cycles;
    bit          calm;

    // key source for prefix sharing in random entries
    logic [7:0]  key_pattern [MAX_KEY_BYTES];
    int          pattern_len;

    stim_row_t   directed_rows [23];

    function automatic void clear_block_state();
        prev_key_len  = '0;
        cur_key_len   = '0;
        keys_seen     = '0;
        shared_len    = '0;
        matching      = 1'b0;
        value_left    = '0;
        group_pos     = '0;
        restart_cnt   = '0;
        body_offset   = '0;
        overflow_seen = 1'b0;
    endfunction

    function automatic void append_word(block_word_t w);
        expected_block_words.insert(expected_block_words.size(), w);
    endfunction

    function automatic void put_word(logic [31:0] w, logic [2:0] nb, logic closing);
        if (word_held)
            append_word(held_word);
        held_word.word    = w;
        held_word.nbytes  = nb;
        held_word.last    = 1'b0;
        held_word.blk_end = closing;
        held_word.ovf     = overflow_seen;
        word_held         = 1'b1;
        words_last_item++;
    endfunction

    function automatic void emit_entry_words();
        logic [KEY_CW-1:0] shared;
        logic [31:0]       w;
        int                idx;
        int                c;
        shared = (shared_len > cur_key_len) ? cur_key_len : shared_len;
        put_word(32'(shared), WORD_BYTES, 1'b0);
        put_word(32'(cur_key_len) - 32'(shared), WORD_BYTES, 1'b0);
        put_word(32'(value_left), WORD_BYTES, 1'b0);
        body_offset += 32'd12;
        idx = int'(shared);
        while (idx < int'(cur_key_len)) begin
            w = '0;
            c = 0;
            while (c < 4 && idx < int'(cur_key_len)) begin
                w |= 32'(key_mem[idx]) << (8 * c);
                c++;
                idx++;
            end
            put_word(w, 3'(c), 1'b0);
            body_offset += 32'(c);
        end
        prev_key_len = cur_key_len;
    endfunction

    function automatic void predict_block_words(cmd_t cmd, logic [7:0] data,
                                                logic [5:0] klen_in, logic [15:0] vlen);
        logic [7:0]        iv;
        logic              restart;
        int                next_pos;
        logic [KEY_CW-1:0] klen;
        word_held       = 1'b0;
        words_last_item = 0;
        case (cmd)
            CMD_BEGIN: begin
                iv      = (interval_reg == 8'd0) ? 8'd1 : interval_reg;
                restart = (group_pos == 8'd0) || (group_pos >= iv);
                if (keys_seen < cur_key_len)
                    prev_key_len = keys_seen;
                klen = (int'(klen_in) > MAX_KEY_BYTES) ? KEY_CW'(MAX_KEY_BYTES) : KEY_CW'(klen_in);
                if (restart) begin
                    if (int'(restart_cnt) < MAX_RESTARTS) begin
                        restart_mem[restart_cnt] = body_offset;
                        restart_cnt++;
                    end else begin
                        overflow_seen = 1'b1;
                    end
                end
                next_pos    = (restart ? 0 : int'(group_pos)) + 1;
                group_pos   = (next_pos >= int'(iv)) ? 8'd0 : 8'(next_pos);
                cur_key_len = klen;
                keys_seen   = '0;
                shared_len  = '0;
                matching    = !restart;
                value_left  = vlen;
                if (klen == '0)
                    emit_entry_words();
            end
            CMD_KEY: begin
                if (keys_seen < cur_key_len) begin
                    if (matching && keys_seen < prev_key_len && key_mem[keys_seen] == data)
                        shared_len++;
                    else
                        matching = 1'b0;
                    key_mem[keys_seen] = data;
                    keys_seen++;
                    if (keys_seen == cur_key_len)
                        emit_entry_words();
                end
            end
            CMD_VALUE: begin
                if (keys_seen == cur_key_len && value_left != 16'd0) begin
                    put_word(32'(data), SINGLE_BYTE, 1'b0);
                    value_left--;
                    body_offset += 32'd1;
                end
            end
            default: begin
                for (int i = 0; i < int'(restart_cnt); i++)
                    put_word(restart_mem[i], WORD_BYTES, 1'b0);
                put_word(32'(restart_cnt), WORD_BYTES, 1'b1);
                clear_block_state();
            end
        endcase
        if (word_held) begin
            held_word.last = 1'b1;
            append_word(held_word);
        end
    endfunction

    function automatic stim_row_t plain(cmd_t c, logic [7:0] d, logic [5:0] k, logic [15:0] v);
        stim_row_t r;
        r      = '0;
        r.cmd  = c;
        r.data = d;
        r.klen = k;
        r.vlen = v;
        return r;
    endfunction

    function automatic stim_row_t known_words(stim_row_t r, logic [1:0] n, logic [2:0] nb,
                                              logic closing, logic [31:0] w0, w1, w2);
        r.n_known       = n;
        r.known_bytes   = nb;
        r.known_end     = closing;
        r.known_word[0] = w0;
        r.known_word[1] = w1;
        r.known_word[2] = w2;
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endfunction

    task automatic send_item(cmd_t cmd, logic [7:0] data, logic [5:0] klen, logic [15:0] vlen);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, vlen, klen, data};
        do @(posedge aclk); while (!s_tready);
        predict_block_words(cmd, data, klen, vlen);
        items_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_block_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_interval(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        interval_reg = value;
    endtask

    task automatic send_entry();
        logic [5:0]  klen;
        logic [15:0] vlen;
        int          nkey;
        int          keep;
        int          sendk;
        int          nval;
        case ($urandom_range(0, 9))
            0, 1:    klen = 6'd0;
            2:       klen = 6'(MAX_KEY_BYTES);
            3:       klen = 6'($urandom_range(0, 63));
            default: klen = 6'($urandom_range(1, 6));
        endcase
        vlen  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        nkey  = (int'(klen) > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(klen);
        keep  = $urandom_range(0, (nkey < pattern_len) ? nkey : pattern_len);
        sendk = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nkey) : nkey;
        send_item(CMD_BEGIN, 8'($urandom), klen, vlen);
        // early value word, dropped by the block
        if (nkey > 0 && $urandom_range(0, 11) == 0) begin
            send_item(CMD_VALUE, 8'($urandom), 6'($urandom), 16'($urandom));
            items_sent--;
        end
        for (int i = 0; i < sendk; i++) begin
            if (i >= keep)
                key_pattern[i] = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            send_item(CMD_KEY, key_pattern[i], 6'($urandom), 16'($urandom));
        end
        pattern_len = sendk;
        if (sendk == nkey && $urandom_range(0, 11) == 0) begin
            send_item(CMD_KEY, 8'($urandom), 6'($urandom), 16'($urandom));
            items_sent--;
        end
        if (sendk == nkey) begin
            nval = (vlen < 16'd5) ? int'(vlen) : $urandom_range(0, 5);
            if ($urandom_range(0, 9) == 0)
                nval++;
            for (int i = 0; i < nval; i++)
                send_item(CMD_VALUE, 8'($urandom), 6'($urandom), 16'($urandom));
        end
    endtask

    task automatic run_phase(logic [7:0] interval, int budget);
        int stop;
        settle();
        write_interval(interval);
        stop = items_sent + budget;
        while (items_sent < stop) begin
            if ($urandom_range(0, 11) == 0)
                send_item(CMD_FINISH, 8'($urandom), 6'($urandom), 16'($urandom));
            else
                send_entry();
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        block_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_block_words.size() == 0) begin
                errors++;
                $display("%0t: word expected none got %0h", $time, m_tdata[31:0]);
            end else begin
                want = expected_block_words.pop_front();
                check_field("out_word", want.word, m_tdata[31:0]);
                check_field("byte_count", 32'(want.nbytes), 32'(m_tdata[34:32]));
                check_field("run_last", 32'(want.last), 32'(m_tlast));
                check_field("block_end", 32'(want.blk_end), 32'(m_tuser[0]));
                check_field("overflow", 32'(want.ovf), 32'(m_tuser[1]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        block_word_t known;
        int          n;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_BEGIN;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        errors       = 0;
        items_sent   = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        pattern_len  = 0;
        word_held    = 1'b0;
        clear_block_state();
        interval_reg = INTERVAL_RESET;

        directed_rows = '{
            // finish on an empty block: just the zero restart count
            known_words(plain(CMD_FINISH, 8'h00, 6'd0, 16'd0), 2'd1, WORD_BYTES, 1'b1,
                        32'd0, 32'd0, 32'd0),
            // empty key: header words right away
            known_words(plain(CMD_BEGIN, 8'h00, 6'd0, 16'd2), 2'd3, WORD_BYTES, 1'b0,
                        32'd0, 32'd0, 32'd2),
            known_words(plain(CMD_VALUE, 8'hFF, 6'd0, 16'd0), 2'd1, SINGLE_BYTE, 1'b0,
                        32'hFF, 32'd0, 32'd0),
            known_words(plain(CMD_VALUE, 8'h00, 6'd0, 16'd0), 2'd1, SINGLE_BYTE, 1'b0,
                        32'h00, 32'd0, 32'd0),
            plain(CMD_VALUE, 8'h5A, 6'd0, 16'd0),     // surplus value word
            plain(CMD_KEY,   8'h11, 6'd0, 16'd0),     // surplus key word
            plain(CMD_BEGIN, 8'h00, 6'd3, 16'd0),
            plain(CMD_VALUE, 8'h77, 6'd0, 16'd0),     // early value word
            plain(CMD_KEY,   8'h00, 6'd0, 16'd0),
            plain(CMD_KEY,   8'hFF, 6'd0, 16'd0),
            plain(CMD_KEY,   8'h80, 6'd0, 16'd0),
            plain(CMD_BEGIN, 8'hFF, 6'd4, 16'hFFFF),
            plain(CMD_KEY,   8'h00, 6'd0, 16'd0),
            plain(CMD_KEY,   8'hFF, 6'd0, 16'd0),
            plain(CMD_KEY,   8'h01, 6'd0, 16'd0),
            plain(CMD_KEY,   8'h02, 6'd0, 16'd0),
            plain(CMD_BEGIN, 8'h00, 6'd63, 16'd0),    // key length saturates
            plain(CMD_KEY,   8'h00, 6'd0, 16'd0),
            plain(CMD_BEGIN, 8'h00, 6'd2, 16'd1),     // abandons the long key
            plain(CMD_KEY,   8'h00, 6'd0, 16'd0),
            plain(CMD_KEY,   8'h33, 6'd0, 16'd0),
            plain(CMD_VALUE, 8'hAA, 6'd0, 16'd0),
            plain(CMD_FINISH, 8'h00, 6'd0, 16'd0)
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].cmd, directed_rows[i].data,
                      directed_rows[i].klen, directed_rows[i].vlen);
            n = int'(directed_rows[i].n_known);
            if (n != 0) begin
                repeat (words_last_item) void'(expected_block_words.pop_back());
                for (int j = 0; j < n; j++) begin
                    known.word    = directed_rows[i].known_word[j];
                    known.nbytes  = directed_rows[i].known_bytes;
                    known.last    = (j == n - 1);
                    known.blk_end = directed_rows[i].known_end && (j == n - 1);
                    known.ovf     = 1'b0;
                    append_word(known);
                end
            end
        end

        run_phase(8'd3, 60);

        // interval zero: every entry restarts, enough of them to fill the restart store
        settle();
        write_interval(8'd0);
        for (int i = 0; i < MAX_RESTARTS + 8; i++)
            send_item(CMD_BEGIN, 8'($urandom), 6'd0, 16'($urandom_range(0, 3)));
        send_entry();
        send_entry();
        send_item(CMD_FINISH, 8'($urandom), 6'($urandom), 16'($urandom));

        run_phase(8'd255, 70);
        run_phase(8'd1, 40);
        run_phase(8'($urandom_range(2, 254)), 60);
        settle();
        calm = 1'b1;
        run_phase(8'd2, 60);
        send_item(CMD_FINISH, 8'($urandom), 6'($urandom), 16'($urandom));

        settle();
        if (errors == 0 && expected_block_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
hdl/pcbb_pkg.sv
hdl/pcbb_ram.sv
hdl/prefix_compressed_block_builder.sv
hdl/pcbb_checker.sv
dv/testbench.sv
